/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg - shared types for the double-ended queue
// Action and status codes, and the request and response word layouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

    // Requested action
    typedef enum logic [2:0] {
        ACT_PUSH_HEAD = 3'd0,
        ACT_PUSH_TAIL = 3'd1,
        ACT_POP_HEAD  = 3'd2,
        ACT_POP_TAIL  = 3'd3,
        ACT_PEEK_HEAD = 3'd4,
        ACT_PEEK_TAIL = 3'd5,
        ACT_FIND      = 3'd6,
        ACT_CLEAR     = 3'd7
    } action_t;

    // Result status
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Request word
    typedef struct packed {
        action_t     action;
        logic [31:0] data_in;
    } req_t;

    // Response word
    typedef struct packed {
        logic [31:0] data_out;
        status_t     status;
        logic [5:0]  position;
        logic [6:0]  count;
        logic        is_empty;
    } rsp_t;

endpackage

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue - bounded deque of data words in a ring buffer
// One request word in, one response word out; find scans the stored entries.
// ----------------------------------------------------------------------------
// Handles one request at a time. After acceptance, push, clear, and any
// failing pop/peek go from the execute state to the response state. A pop
// or peek that returns data passes through an extra read-wait state for the
// registered memory read. Find compares the stored entries in order from the
// head, stops at the first match or after the last entry, and on an empty
// queue goes straight to the response state. The next request is taken only
// once the response has been presented and the block is idle again, so a new
// request is never taken before the last one is through. The entry memory is
// single-port (one access per cycle). Every address except the push-at-head
// slot goes through the one head-relative slot adder. Stored entries have no
// reset; of the queue state only the head index and the count are cleared.
// A response that is held by rsp_stall delays the next response. One further
// request is still taken and worked on. Its response then waits and req_stall
// stays high until the held response is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_FIND,
        S_RESP
    } state_t;

    state_t          state_reg;
    action_t         act_reg;
    logic [SW-1:0]   word_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   scan_reg;
    logic [SW-1:0]   data_reg;
    status_t         status_reg;
    logic [AW-1:0]   pos_reg;
    rsp_t            rsp_reg;
    logic            rsp_valid_reg;

    logic [SW-1:0]   mem [DEPTH];
    logic [SW-1:0]   rd_data_reg;

    logic [AW-1:0]   offset;
    logic [AW:0]     slot_sum;
    logic [AW-1:0]   slot;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   scan_inc;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic            is_full;
    logic            is_none;
    logic            scan_last;
    logic            rsp_free;

    assign is_full   = (count_reg == FULL_CNT);
    assign is_none   = (count_reg == '0);
    assign scan_inc  = scan_reg + 1'b1;
    assign scan_last = ((CW'(scan_reg) + 1'b1) == count_reg);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Offset select for the shared slot adder
    always_comb
    begin
        offset = '0;
        case (state_reg)
            S_EXEC:
            begin
                case (act_reg) inside
                    ACT_PUSH_TAIL:                offset = AW'(count_reg);
                    ACT_POP_TAIL, ACT_PEEK_TAIL:  offset = AW'(count_reg - 1'b1);
                    default:                      offset = '0;
                endcase
            end
            S_RDWAIT: offset = AW'(1);
            S_FIND:   offset = scan_inc;
            default:  offset = '0;
        endcase
    end

    // Shared slot adder: (head + offset) mod DEPTH, both operands below DEPTH
    assign slot_sum = {1'b0, head_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= DEPTH_SUM) ? AW'(slot_sum - DEPTH_SUM)
                                              : slot_sum[AW-1:0];
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;

    // Memory port control
    assign mem_addr = (act_reg == ACT_PUSH_HEAD) ? head_dec : slot;
    assign mem_we   = (state_reg == S_EXEC) && !is_full &&
                      ((act_reg == ACT_PUSH_HEAD) || (act_reg == ACT_PUSH_TAIL));

    // Entry memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= word_reg;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_PUSH_HEAD;
            word_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            data_reg      <= '0;
            status_reg    <= ST_OK;
            pos_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        act_reg   <= req.action;
                        word_reg  <= req.data_in[SW-1:0];
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    data_reg   <= '0;
                    pos_reg    <= '0;
                    status_reg <= ST_OK;
                    state_reg  <= S_RESP;
                    unique case (act_reg)
                        ACT_PUSH_HEAD:
                        begin
                            if (is_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                head_reg  <= head_dec;
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_TAIL:
                        begin
                            if (is_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        ACT_POP_HEAD, ACT_POP_TAIL, ACT_PEEK_HEAD, ACT_PEEK_TAIL:
                        begin
                            if (is_none)
                            begin
                                status_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                state_reg <= S_RDWAIT;
                            end
                        end
                        ACT_FIND:
                        begin
                            scan_reg <= '0;
                            if (is_none)
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_reg <= S_FIND;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            head_reg  <= '0;
                            count_reg <= '0;
                        end
                    endcase
                end

                // read data for the head or tail entry is now valid
                S_RDWAIT:
                begin
                    data_reg  <= rd_data_reg;
                    state_reg <= S_RESP;
                    if (act_reg == ACT_POP_HEAD)
                    begin
                        head_reg  <= slot;
                        count_reg <= count_reg - 1'b1;
                    end
                    else if (act_reg == ACT_POP_TAIL)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end

                // one entry compared per cycle, next read already issued
                S_FIND:
                begin
                    if (rd_data_reg == word_reg)
                    begin
                        status_reg <= ST_OK;
                        pos_reg    <= scan_reg;
                        state_reg  <= S_RESP;
                    end
                    else if (scan_last)
                    begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                    end
                end

                S_RESP:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.data_out <= 32'(data_reg);
                        rsp_reg.status   <= status_reg;
                        rsp_reg.position <= 6'(pos_reg);
                        rsp_reg.count    <= 7'(count_reg);
                        rsp_reg.is_empty <= is_none;
                        rsp_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while another is in progress");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_empty) |-> (rsp.count == '0))
        else $error("empty flag with nonzero count");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.data_out == '0))
        else $error("data returned on a failed action");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && (status_reg == ST_FULL)) |-> is_full)
        else $error("full status while queue not full");

endmodule

/* tb/double_ended_queue_test.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_test - self-checking bench for the double-ended queue
// Drives request words through the valid/stall channel, mirrors the ring
// buffer in a shadow model, and checks every response word field by field.
// Directed corner cases come first, then fill, drain and mixed random phases
// with random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int QUEUE_DEPTH  = 64;
    localparam int RANDOM_WORDS = 1000;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 250;
    localparam int CALM_FROM    = 450;
    localparam int CALM_TO      = 650;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Request words waiting to be driven, responses waiting to arrive
    req_t pending_words[$];
    rsp_t awaited_results[$];

    // Shadow copy of the ring buffer
    logic [31:0] mirror_words[QUEUE_DEPTH];
    logic [5:0]  mirror_head = '0;
    logic [6:0]  mirror_count = '0;

    int cycle_count = 0;
    int words_taken = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int errors = 0;

    double_ended_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Apply one action to the shadow deque and return the response it gives
    function automatic rsp_t deque_outcome(input req_t w);
        rsp_t       o;
        logic [5:0] slot;
        bit         found;
        o = '0;
        o.status = ST_OK;
        found = 1'b0;
        case (w.action)
            ACT_PUSH_HEAD, ACT_PUSH_TAIL:
            begin
                if (mirror_count == QUEUE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    if (w.action == ACT_PUSH_HEAD)
                    begin
                        mirror_head = mirror_head - 6'd1;
                        slot = mirror_head;
                    end
                    else
                        slot = mirror_head + mirror_count[5:0];
                    mirror_words[slot] = w.data_in;
                    mirror_count = mirror_count + 7'd1;
                end
            end
            ACT_POP_HEAD, ACT_PEEK_HEAD:
            begin
                if (mirror_count == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.data_out = mirror_words[mirror_head];
                    if (w.action == ACT_POP_HEAD)
                    begin
                        mirror_head = mirror_head + 6'd1;
                        mirror_count = mirror_count - 7'd1;
                    end
                end
            end
            ACT_POP_TAIL, ACT_PEEK_TAIL:
            begin
                if (mirror_count == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    slot = mirror_head + mirror_count[5:0] - 6'd1;
                    o.data_out = mirror_words[slot];
                    if (w.action == ACT_POP_TAIL)
                        mirror_count = mirror_count - 7'd1;
                end
            end
            ACT_FIND:
            begin
                o.status = ST_NOT_FOUND;
                for (int i = 0; i < mirror_count; i++)
                begin
                    slot = mirror_head + 6'(i);
                    if (!found && mirror_words[slot] == w.data_in)
                    begin
                        found = 1'b1;
                        o.status = ST_OK;
                        o.position = 6'(i);
                    end
                end
            end
            default:
            begin
                mirror_count = '0;
                mirror_head = '0;
            end
        endcase
        o.count = mirror_count;
        o.is_empty = (mirror_count == 0);
        return o;
    endfunction

    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        // small values repeat often, so find gets real hits
        if (pick < 5)
            return 32'($urandom_range(0, 15));
        else if (pick == 5)
            return 32'h0000_0000;
        else if (pick == 6)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic add_word(input action_t a, input logic [31:0] d);
        req_t w;
        w.action = a;
        w.data_in = d;
        pending_words.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int made;
        int seg_len;
        int mode;
        int push_pct;
        int pop_pct;
        int r;
        int k;

        // empty queue corners
        add_word(ACT_POP_HEAD, 32'h1111_1111);
        add_word(ACT_POP_TAIL, 32'h2222_2222);
        add_word(ACT_PEEK_HEAD, 32'h0);
        add_word(ACT_PEEK_TAIL, 32'hFFFF_FFFF);
        add_word(ACT_FIND, 32'h0);
        add_word(ACT_CLEAR, 32'hFFFF_FFFF);
        // a few entries, then peek, find and pop from both ends
        add_word(ACT_PUSH_HEAD, 32'h0000_0000);
        add_word(ACT_PUSH_TAIL, 32'hFFFF_FFFF);
        add_word(ACT_PUSH_HEAD, 32'hA5A5_A5A5);
        add_word(ACT_PEEK_HEAD, 32'h0);
        add_word(ACT_PEEK_TAIL, 32'h0);
        add_word(ACT_FIND, 32'hFFFF_FFFF);
        add_word(ACT_FIND, 32'h1234_5678);
        add_word(ACT_POP_TAIL, 32'h0);
        add_word(ACT_POP_HEAD, 32'h0);
        add_word(ACT_FIND, 32'h0000_0000);
        add_word(ACT_POP_HEAD, 32'h0);
        add_word(ACT_POP_TAIL, 32'h0);
        add_word(ACT_FIND, 32'h0000_0000);
        add_word(ACT_PUSH_TAIL, 32'h5A5A_5A5A);
        add_word(ACT_CLEAR, 32'h0);
        add_word(ACT_PEEK_TAIL, 32'h0);

        // random phases: fill (reaches full), drain (reaches empty), mixed
        made = 0;
        mode = 0;
        while (made < RANDOM_WORDS)
        begin
            if (made == 0)
                seg_len = 160;
            else
            begin
                mode = $urandom_range(0, 9);
                seg_len = (mode < 4) ? $urandom_range(80, 160) : $urandom_range(40, 100);
            end
            if (mode < 4)
            begin
                push_pct = 80;
                pop_pct = 8;
            end
            else if (mode < 7)
            begin
                push_pct = 10;
                pop_pct = 75;
            end
            else
            begin
                push_pct = 40;
                pop_pct = 40;
            end
            for (int n = 0; n < seg_len; n++)
            begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, 3);
                if (r < push_pct)
                    add_word(k[0] ? ACT_PUSH_TAIL : ACT_PUSH_HEAD, random_word());
                else if (r < push_pct + pop_pct)
                    add_word(k[0] ? ACT_POP_TAIL : ACT_POP_HEAD, random_word());
                else if (r < 98)
                begin
                    if (k == 0)
                        add_word(ACT_PEEK_HEAD, random_word());
                    else if (k == 1)
                        add_word(ACT_PEEK_TAIL, random_word());
                    else
                        add_word(ACT_FIND, random_word());
                end
                else
                    add_word(ACT_CLEAR, random_word());
            end
            made += seg_len;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

    // Request driver: new word only when the current one is taken or none is up
    always @(posedge clk)
    begin
        bit idle_now;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                awaited_results.push_back(deque_outcome(req));
                words_taken <= words_taken + 1;
            end
            if (!req_valid || !req_stall)
            begin
                idle_now = (words_taken >= CALM_FROM && words_taken < CALM_TO) ? 1'b0 :
                           ($urandom_range(0, 99) < 32);
                if (pending_words.size() != 0 && !idle_now)
                begin
                    req <= pending_words.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response stall: random, calm stretch, and one long hold-off to fill the block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                rsp_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (results_seen >= CALM_FROM && results_seen < CALM_TO)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 32);
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("data_out", want.data_out, rsp.data_out);
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("position", 32'(want.position), 32'(rsp.position));
                check_field("count", 32'(want.count), 32'(rsp.count));
                check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** double_ended_queue: FAILED **");
            $finish;
        end
    end

endmodule

/* files.f */
rtl/core/deq_pkg.sv
rtl/core/double_ended_queue.sv
tb/double_ended_queue_test.sv
